### rtl/core/gwn_pkg.sv
// ----------------------------------------------------------------------------
// gwn_pkg
// Shared types and constants of the grid window nearest code matcher:
// field widths, request codes and the control words of the distance unit.
// ----------------------------------------------------------------------------
package gwn_pkg;

    // fixed field widths
    localparam int REQ_BITS      = 2;
    localparam int COORD_BITS    = 13;
    localparam int OUT_CODE_BITS = 20;
    localparam int THR_BITS      = 8;
    localparam int SQ_BITS       = 2 * COORD_BITS;
    localparam int DIST_BITS     = SQ_BITS + 1;

    localparam logic [THR_BITS-1:0] THR_RESET = 8'd32;

    // parameter defaults
    localparam int GRID_WIDTH_DEF = 512;
    localparam int GRID_HEIGHT_DEF = 512;
    localparam int FRAC_BITS_DEF  = 4;
    localparam int MAX_RADIUS_DEF = 8;
    localparam int CODE_BITS_DEF  = 20;

    // request codes
    typedef enum logic [REQ_BITS-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    // distance unit operations
    typedef enum logic [1:0] {
        DOP_NONE,
        DOP_INIT,
        DOP_FIRST,
        DOP_SECOND
    } t_dist_op;

    typedef struct packed {
        t_dist_op              op;
        logic [COORD_BITS-1:0] a;
        logic [COORD_BITS-1:0] b;
    } t_dist_ctrl;

    typedef struct packed {
        logic hit;
    } t_dist_stat;

endpackage

### rtl/core/gwn_if.sv
// ----------------------------------------------------------------------------
// gwn_if
// Valid/ready channels of the matcher: request words, result words and
// the threshold register write channel.
// ----------------------------------------------------------------------------
interface gwn_req_if;
    import gwn_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [REQ_BITS-1:0]      req_type;
    logic [COORD_BITS-1:0]    point_x;
    logic [COORD_BITS-1:0]    point_y;
    logic [OUT_CODE_BITS-1:0] point_code;
    logic                     has_feature;
    logic                     in_mask;

    modport source (output valid, req_type, point_x, point_y, point_code,
                    has_feature, in_mask, input ready);
    modport sink   (input valid, req_type, point_x, point_y, point_code,
                    has_feature, in_mask, output ready);
endinterface

interface gwn_res_if;
    import gwn_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OUT_CODE_BITS-1:0] query_code;
    logic [OUT_CODE_BITS-1:0] match_code;
    logic                     found;

    modport source (output valid, query_code, match_code, found, input ready);
    modport sink   (input valid, query_code, match_code, found, output ready);
endinterface

interface gwn_cfg_if;
    import gwn_pkg::*;

    logic                valid;
    logic                ready;
    logic [THR_BITS-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### rtl/core/grid_window_nearest_code_match.sv
// ----------------------------------------------------------------------------
// grid_window_nearest_code_match
// Stores reference points in a pixel grid and, per query, scans the
// window around the query cell for the nearest stored code.
// ----------------------------------------------------------------------------
// Load and unused words leave the sequencer idle. A query loads the squared
// threshold, then per window cell skips it (outside grid), reads it (empty)
// or reads it and squares dx, then dy (occupied): one read port and one
// shared squarer. Reset and each clear word sweep 2^(clog2(W)+clog2(H))
// cells (262144 by default), request side not ready; cfg is always taken.
module grid_window_nearest_code_match #(
    parameter int GRID_WIDTH  = gwn_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = gwn_pkg::GRID_HEIGHT_DEF,
    parameter int FRAC_BITS   = gwn_pkg::FRAC_BITS_DEF,
    parameter int MAX_RADIUS  = gwn_pkg::MAX_RADIUS_DEF,
    parameter int CODE_BITS   = gwn_pkg::CODE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gwn_cfg_if.sink    i_cfg,
    gwn_req_if.sink    i_req,
    gwn_res_if.source  o_res
);
    import gwn_pkg::*;

    localparam int CXW       = COORD_BITS - FRAC_BITS;
    localparam int XB        = $clog2(GRID_WIDTH);
    localparam int YB        = $clog2(GRID_HEIGHT);
    localparam int AW        = XB + YB;
    localparam int GW        = CXW + 2;
    localparam int RADW      = $clog2(MAX_RADIUS + 1);
    localparam int CELL_BITS = 1 + 2 * COORD_BITS + CODE_BITS;
    localparam logic [THR_BITS:0] ROUND_UP = (THR_BITS + 1)'((1 << FRAC_BITS) - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_READ,
        S_CHECK,
        S_SECOND,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [AW-1:0]            r_clr;
    logic [THR_BITS-1:0]      r_thr;
    logic [COORD_BITS-1:0]    r_px;
    logic [COORD_BITS-1:0]    r_py;
    logic [CODE_BITS-1:0]     r_qcode;
    logic                     r_kept;
    logic signed [GW-1:0]     r_gx;
    logic signed [GW-1:0]     r_gy;
    logic signed [GW-1:0]     r_xhi;
    logic signed [GW-1:0]     r_ylo;
    logic signed [GW-1:0]     r_yhi;
    logic [CODE_BITS-1:0]     r_match;
    logic                     r_found;
    logic                     r_out_valid;
    logic [OUT_CODE_BITS-1:0] r_out_qcode;
    logic [OUT_CODE_BITS-1:0] r_out_match;
    logic                     r_out_found;

    logic                  accept;
    t_req                  req;
    logic                  kept;
    logic [CXW-1:0]        cx;
    logic [CXW-1:0]        cy;
    logic [CODE_BITS-1:0]  in_code;
    logic [THR_BITS:0]     rad_raw;
    logic [RADW-1:0]       radius;
    logic signed [GW-1:0]  cx_s;
    logic signed [GW-1:0]  cy_s;
    logic signed [GW-1:0]  rad_s;
    logic                  in_grid;
    logic                  last_y;
    logic                  last_x;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [CELL_BITS-1:0]  mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [CELL_BITS-1:0]  mem_rdata;

    logic                  cell_valid;
    logic [COORD_BITS-1:0] cell_x;
    logic [COORD_BITS-1:0] cell_y;
    logic [CODE_BITS-1:0]  cell_code;

    t_dist_ctrl            dist_ctrl;
    t_dist_stat            dist_stat;

    // threshold register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg.valid) begin
            r_thr <= i_cfg.data;
        end
    end

    // request decode
    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign req         = t_req'(i_req.req_type);
    assign kept        = i_req.has_feature && i_req.in_mask;
    assign cx          = CXW'(i_req.point_x >> FRAC_BITS);
    assign cy          = CXW'(i_req.point_y >> FRAC_BITS);
    assign in_code     = CODE_BITS'(i_req.point_code);

    // window radius = ceil(threshold), saturated
    always_comb begin
        rad_raw = ({1'b0, r_thr} + ROUND_UP) >> FRAC_BITS;
        if (rad_raw > (THR_BITS + 1)'(MAX_RADIUS)) begin
            radius = RADW'(MAX_RADIUS);
        end else begin
            radius = RADW'(rad_raw);
        end
        cx_s  = $signed(GW'(cx));
        cy_s  = $signed(GW'(cy));
        rad_s = $signed(GW'(radius));
    end

    // window walk status
    assign in_grid = (r_gx >= 0) && (int'(r_gx) < GRID_WIDTH)
                  && (r_gy >= 0) && (int'(r_gy) < GRID_HEIGHT);
    assign last_y  = (r_gy == r_yhi);
    assign last_x  = (r_gx == r_xhi);

    // cell store: clearing sweep or load write, window read
    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = '0;
        end else begin
            mem_we    = accept && (req == REQ_LOAD) && kept
                     && (int'(cx) < GRID_WIDTH) && (int'(cy) < GRID_HEIGHT);
            mem_waddr = {XB'(cx), YB'(cy)};
            mem_wdata = {1'b1, i_req.point_x, i_req.point_y, in_code};
        end
        mem_re    = (r_state == S_READ) && in_grid;
        mem_raddr = {XB'(r_gx), YB'(r_gy)};
    end

    assign {cell_valid, cell_x, cell_y, cell_code} = mem_rdata;

    gwn_grid_mem #(
        .ADDR_BITS (AW),
        .DATA_BITS (CELL_BITS)
    ) u_grid_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // distance unit control
    always_comb begin
        dist_ctrl.op = DOP_NONE;
        dist_ctrl.a  = r_px;
        dist_ctrl.b  = cell_x;
        case (r_state)
            S_INIT: begin
                dist_ctrl.op = DOP_INIT;
                dist_ctrl.a  = COORD_BITS'(r_thr);
                dist_ctrl.b  = '0;
            end
            S_CHECK: begin
                if (cell_valid) begin
                    dist_ctrl.op = DOP_FIRST;
                end
            end
            S_SECOND: begin
                dist_ctrl.op = DOP_SECOND;
                dist_ctrl.a  = r_py;
                dist_ctrl.b  = cell_y;
            end
            default: ;
        endcase
    end

    gwn_dist_unit u_dist_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (dist_ctrl),
        .o_stat  (dist_stat)
    );

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // S_DONE handles the result register on its own
            if (o_res.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_px    <= i_req.point_x;
                        r_py    <= i_req.point_y;
                        r_qcode <= in_code;
                        r_kept  <= kept;
                        r_gx    <= cx_s - rad_s;
                        r_gy    <= cy_s - rad_s;
                        r_xhi   <= cx_s + rad_s;
                        r_ylo   <= cy_s - rad_s;
                        r_yhi   <= cy_s + rad_s;
                        r_match <= '0;
                        r_found <= 1'b0;
                        case (req)
                            REQ_QUERY: r_state <= S_INIT;
                            REQ_CLEAR: begin
                                r_clr   <= '0;
                                r_state <= S_CLEAR;
                            end
                            default: ;
                        endcase
                    end
                end
                S_INIT: begin
                    r_state <= r_kept ? S_READ : S_DONE;
                end
                S_READ: begin
                    if (in_grid) begin
                        r_state <= S_CHECK;
                    end else begin
                        // skip a cell outside the grid
                        if (last_y) begin
                            r_gy <= r_ylo;
                            r_gx <= r_gx + 1'b1;
                        end else begin
                            r_gy <= r_gy + 1'b1;
                        end
                        r_state <= (last_y && last_x) ? S_DONE : S_READ;
                    end
                end
                S_CHECK, S_SECOND: begin
                    if (r_state == S_CHECK && cell_valid) begin
                        r_state <= S_SECOND;
                    end else begin
                        if (dist_stat.hit) begin
                            r_match <= cell_code;
                            r_found <= 1'b1;
                        end
                        if (last_y) begin
                            r_gy <= r_ylo;
                            r_gx <= r_gx + 1'b1;
                        end else begin
                            r_gy <= r_gy + 1'b1;
                        end
                        r_state <= (last_y && last_x) ? S_DONE : S_READ;
                    end
                end
                S_DONE: begin
                    // wait for the result register to be free
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_qcode <= OUT_CODE_BITS'(r_qcode);
                        r_out_match <= OUT_CODE_BITS'(r_match);
                        r_out_found <= r_found;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.query_code = r_out_qcode;
    assign o_res.match_code = r_out_match;
    assign o_res.found      = r_out_found;

endmodule

### rtl/core/gwn_grid_mem.sv
// ----------------------------------------------------------------------------
// gwn_grid_mem
// Single write, single read cell store with a registered read port.
// ----------------------------------------------------------------------------
module gwn_grid_mem #(
    parameter int ADDR_BITS = 18,
    parameter int DATA_BITS = 47
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/gwn_dist_unit.sv
// ----------------------------------------------------------------------------
// gwn_dist_unit
// Shared absolute-difference squarer. Loads the squared threshold, then
// sums dx^2 and dy^2 over two steps and keeps the running best distance.
// ----------------------------------------------------------------------------
module gwn_dist_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gwn_pkg::t_dist_ctrl i_ctrl,
    output gwn_pkg::t_dist_stat o_stat
);
    import gwn_pkg::*;

    logic [COORD_BITS-1:0] diff;
    logic [SQ_BITS-1:0]    sq;
    logic [DIST_BITS-1:0]  sum;
    logic                  less;
    logic [SQ_BITS-1:0]    r_sq;
    logic [DIST_BITS-1:0]  r_best;

    // |a - b|^2, plus the partial sum of the second step
    always_comb begin
        diff = (i_ctrl.a > i_ctrl.b) ? (i_ctrl.a - i_ctrl.b) : (i_ctrl.b - i_ctrl.a);
        sq   = SQ_BITS'(diff) * SQ_BITS'(diff);
        sum  = {1'b0, r_sq} + {1'b0, sq};
        less = sum < r_best;
    end

    assign o_stat.hit = (i_ctrl.op == DOP_SECOND) && less;

    // partial square and best distance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
        end else begin
            case (i_ctrl.op)
                DOP_INIT:   r_best <= {1'b0, sq};
                DOP_SECOND: if (less) begin
                    r_best <= sum;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == DOP_FIRST) begin
            r_sq <= sq;
        end
    end

endmodule
